### design/twv_pkg.sv
// Shared types and fixed widths for the trapped-water block.
// No dependencies; every other design file imports this package.
`default_nettype none

package twv_pkg;

   localparam int IN_H_W  = 16;  // width of the bar height port
   localparam int TOTAL_W = 26;  // width of the water total port

   // Control that travels with a finished profile from front to back
   typedef struct packed {
      logic bank;     // store bank that holds the profile
      logic dropped;  // bars were dropped because the bank was full
   } job_ctl_type;

   // Back tells the front that it has finished with a bank
   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

endpackage

`default_nettype wire

### design/trapped_water_volume.sv
// Top level of the trapped-water block: front end, job queue, back end.
// Depends on twv_pkg, twv_front, twv_jobq and twv_back.
//
//  channel   handshake     payload
//  request   push / full   req_bar_height, req_last_bar
//  response  empty / pop   rsp_water_total, rsp_overflowed
//
// Each bar is taken in one cycle while full is low. After the last bar the walk
// visits each stored bar through ST_READ, the registered read of the height
// store, and ST_STEP; ST_IDLE takes the job and ST_FINISH loads the result register.
// The store has two banks: the next profile loads while the previous one is
// walked; full rises when both banks wait for the walk. A result left waiting
// holds the walk, and with it the bank, until it is popped.
// Reset is synchronous and clears control only; the store needs no clearing.
`default_nettype none

module trapped_water_volume #(
   parameter int MAX_BARS    = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [twv_pkg::IN_H_W-1:0]  req_bar_height,
   input  wire logic                        req_last_bar,
   output logic                             empty,
   input  wire logic                        pop,
   output logic [twv_pkg::TOTAL_W-1:0]      rsp_water_total,
   output logic                             rsp_overflowed
);
   import twv_pkg::*;

   localparam int AW = $clog2(MAX_BARS);
   localparam int CW = $clog2(MAX_BARS + 1);
   localparam int SW = (HEIGHT_BITS < IN_H_W) ? HEIGHT_BITS : IN_H_W;

   logic          wr_en;
   logic [AW:0]   wr_addr;
   logic [SW-1:0] wr_data;
   logic          job_push;
   logic [CW-1:0] job_count;
   job_ctl_type   job_ctl;
   logic          q_avail;
   logic [CW-1:0] q_count;
   job_ctl_type   q_ctl;
   logic          q_pop;
   done_type      done;

   twv_front #(.MAX_BARS(MAX_BARS), .SW(SW), .AW(AW), .CW(CW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .bar_height (req_bar_height),
      .last_bar   (req_last_bar),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .job_push   (job_push),
      .job_count  (job_count),
      .job_ctl    (job_ctl),
      .done       (done)
   );

   twv_jobq #(.CW(CW)) u_jobq (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_count (job_count),
      .push_ctl   (job_ctl),
      .pop        (q_pop),
      .avail      (q_avail),
      .head_count (q_count),
      .head_ctl   (q_ctl)
   );

   twv_back #(.SW(SW), .AW(AW), .CW(CW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .job_avail   (q_avail),
      .job_count   (q_count),
      .job_ctl     (q_ctl),
      .job_pop     (q_pop),
      .done        (done),
      .pop         (pop),
      .empty       (empty),
      .water_total (rsp_water_total),
      .overflowed  (rsp_overflowed)
   );

endmodule

`default_nettype wire

### design/twv_front.sv
// Front end: accepts bars, writes them into the current store bank and
// hands each finished profile to the job queue. Depends on twv_pkg.
`default_nettype none

module twv_front #(
   parameter int MAX_BARS = 1024,
   parameter int SW       = 16,
   parameter int AW       = 10,
   parameter int CW       = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [twv_pkg::IN_H_W-1:0] bar_height,
   input  wire logic                       last_bar,
   output logic                            wr_en,
   output logic [AW:0]                     wr_addr,
   output logic [SW-1:0]                   wr_data,
   output logic                            job_push,
   output logic [CW-1:0]                   job_count,
   output twv_pkg::job_ctl_type            job_ctl,
   input  wire twv_pkg::done_type          done
);
   import twv_pkg::*;

   logic          bank_ff, bank_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          drop_ff, drop_in;
   logic [1:0]    busy_ff, busy_in;
   logic          accept;
   logic          room;

   // A bank stays busy from the end of its profile until the walk is done
   assign full   = busy_ff[bank_ff];
   assign accept = push & ~full;
   assign room   = (cnt_ff < CW'(MAX_BARS));

   assign wr_en   = accept & room;
   assign wr_addr = {bank_ff, cnt_ff[AW-1:0]};
   assign wr_data = bar_height[SW-1:0];

   assign job_push        = accept & last_bar;
   assign job_count       = room ? cnt_ff + CW'(1) : cnt_ff;
   assign job_ctl.bank    = bank_ff;
   assign job_ctl.dropped = drop_ff | ~room;

   always_comb begin
      bank_in = bank_ff;
      cnt_in  = cnt_ff;
      drop_in = drop_ff;
      busy_in = busy_ff;
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (accept) begin
         if (last_bar) begin
            // close the profile and switch to the other bank
            busy_in[bank_ff] = 1'b1;
            bank_in          = ~bank_ff;
            cnt_in           = '0;
            drop_in          = 1'b0;
         end else if (room) begin
            cnt_in = cnt_ff + CW'(1);
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         bank_ff <= bank_in;
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
         busy_ff <= busy_in;
      end
   end

endmodule

`default_nettype wire

### design/twv_jobq.sv
// Two-entry queue of finished profiles between front and back.
// Depends on twv_pkg for the job control struct.
`default_nettype none

module twv_jobq #(
   parameter int CW = 11
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [CW-1:0]        push_count,
   input  wire twv_pkg::job_ctl_type push_ctl,
   input  wire logic                 pop,
   output logic                      avail,
   output logic [CW-1:0]             head_count,
   output twv_pkg::job_ctl_type      head_ctl
);
   import twv_pkg::*;

   logic [CW-1:0] count_ff [2];
   job_ctl_type   ctl_ff   [2];
   logic          wptr_ff, wptr_in;
   logic          rptr_ff, rptr_in;
   logic [1:0]    fill_ff, fill_in;

   assign avail      = (fill_ff != 2'd0);
   assign head_count = count_ff[rptr_ff];
   assign head_ctl   = ctl_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wptr_in = ~wptr_ff;
      end
      if (pop & avail) begin
         rptr_in = ~rptr_ff;
      end
      unique case ({push, pop & avail})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         count_ff[wptr_ff] <= push_count;
         ctl_ff[wptr_ff]   <= push_ctl;
      end
   end

endmodule

`default_nettype wire

### design/twv_back.sv
// Back end: holds the two-bank height store and runs the two-pointer walk
// over one profile at a time, then loads the result register. Uses twv_pkg.
`default_nettype none

module twv_back #(
   parameter int SW = 16,
   parameter int AW = 10,
   parameter int CW = 11
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [AW:0]                 wr_addr,
   input  wire logic [SW-1:0]               wr_data,
   input  wire logic                        job_avail,
   input  wire logic [CW-1:0]               job_count,
   input  wire twv_pkg::job_ctl_type        job_ctl,
   output logic                             job_pop,
   output twv_pkg::done_type                done,
   input  wire logic                        pop,
   output logic                             empty,
   output logic [twv_pkg::TOTAL_W-1:0]      water_total,
   output logic                             overflowed
);
   import twv_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_FINISH
   } state_type;

   logic [SW-1:0] mem [2**(AW+1)];

   state_type          state_ff, state_in;
   logic               bank_ff, bank_in;
   logic               drop_ff, drop_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [AW-1:0]      right_ff, right_in;
   logic [SW-1:0]      lpeak_ff, lpeak_in;
   logic [SW-1:0]      rpeak_ff, rpeak_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               outv_ff, outv_in;
   logic [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic               out_drop_ff, out_drop_in;
   logic [SW-1:0]      hl_ff, hr_ff;
   logic [SW-1:0]      depth;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] total_sat;
   logic               go_left;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      hl_ff <= mem[{bank_ff, left_ff[AW-1:0]}];
      hr_ff <= mem[{bank_ff, right_ff}];
   end

   assign empty       = ~outv_ff;
   assign water_total = out_total_ff;
   assign overflowed  = out_drop_ff;

   assign go_left = (hl_ff <= hr_ff);
   assign depth   = go_left ? lpeak_ff - hl_ff : rpeak_ff - hr_ff;
   assign sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(depth);
   // saturate the running total
   assign total_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      drop_in      = drop_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      lpeak_in     = lpeak_ff;
      rpeak_in     = rpeak_ff;
      total_in     = total_ff;
      outv_in      = outv_ff & ~pop;
      out_total_in = out_total_ff;
      out_drop_in  = out_drop_ff;
      job_pop      = 1'b0;
      done.valid   = 1'b0;
      done.bank    = bank_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_avail) begin
               job_pop  = 1'b1;
               bank_in  = job_ctl.bank;
               drop_in  = job_ctl.dropped;
               left_in  = '0;
               right_in = AW'(job_count - CW'(1));
               lpeak_in = '0;
               rpeak_in = '0;
               total_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (go_left) begin
               if (hl_ff > lpeak_ff) begin
                  lpeak_in = hl_ff;
               end else begin
                  total_in = total_sat;
               end
               left_in = left_ff + CW'(1);
            end else begin
               if (hr_ff > rpeak_ff) begin
                  rpeak_in = hr_ff;
               end else begin
                  total_in = total_sat;
               end
               right_in = right_ff - AW'(1);
            end
            state_in = (left_in > CW'(right_in)) ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (~outv_ff | pop) begin
               outv_in      = 1'b1;
               out_total_in = total_ff;
               out_drop_in  = drop_ff;
               done.valid   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
      end
      bank_ff      <= bank_in;
      drop_ff      <= drop_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      lpeak_ff     <= lpeak_in;
      rpeak_ff     <= rpeak_in;
      total_ff     <= total_in;
      out_total_ff <= out_total_in;
      out_drop_ff  <= out_drop_in;
   end

endmodule

`default_nettype wire

### design/twv_checker.sv
// Port-level checks for trapped_water_volume, attached by bind.
// Depends on twv_pkg for the result width.
`default_nettype none

module twv_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        push,
   input wire logic                        full,
   input wire logic                        req_last_bar,
   input wire logic                        empty,
   input wire logic                        pop,
   input wire logic [twv_pkg::TOTAL_W-1:0] rsp_water_total,
   input wire logic                        rsp_overflowed
);
   import twv_pkg::*;

   // nothing waits and nothing stalls right after a reset cycle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not idle after reset");

   // a bank fills up only when a profile has just been closed
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push && !full && req_last_bar))
      else $error("full rose without a closing bar");

   // a waiting result holds until it is taken
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_water_total)
                            && $stable(rsp_overflowed)))
      else $error("waiting result changed");

endmodule

bind trapped_water_volume twv_checker u_twv_checker (
   .clock           (clock),
   .reset           (reset),
   .push            (push),
   .full            (full),
   .req_last_bar    (req_last_bar),
   .empty           (empty),
   .pop             (pop),
   .rsp_water_total (rsp_water_total),
   .rsp_overflowed  (rsp_overflowed)
);

`default_nettype wire

### dv/water_check_pkg.sv
// Scoreboard for the trapped-water block: tracks the profile being loaded,
// predicts the water total of each finished profile and checks the results.
// Depends on twv_pkg for the port widths.
package water_check_pkg;

   import twv_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam logic [TOTAL_W-1:0] TOTAL_CEIL = '1;

   typedef struct packed {
      logic [TOTAL_W-1:0] water_total;
      logic               overflowed;
   } water_result_t;

   class water_scoreboard;
      logic [IN_H_W-1:0] profile_q[$];
      logic              bars_dropped;
      water_result_t     expected_q[$];
      int unsigned       errors;

      function new();
         bars_dropped = 1'b0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Store the bar; on the last one, walk the profile from both ends.
      function void note_bar(logic [IN_H_W-1:0] height, logic last);
         longint            lo;
         longint            hi;
         logic [IN_H_W-1:0] left_pk;
         logic [IN_H_W-1:0] right_pk;
         longint unsigned   acc;
         water_result_t     res;
         if (profile_q.size() < STORE_DEPTH) begin
            profile_q.push_back(height);
         end else begin
            bars_dropped = 1'b1;
         end
         if (!last) return;
         lo = 0;
         hi = profile_q.size() - 1;
         left_pk = '0;
         right_pk = '0;
         acc = 0;
         while (lo <= hi) begin
            if (profile_q[lo] <= profile_q[hi]) begin
               if (profile_q[lo] > left_pk) left_pk = profile_q[lo];
               else acc += left_pk - profile_q[lo];
               lo++;
            end else begin
               if (profile_q[hi] > right_pk) right_pk = profile_q[hi];
               else acc += right_pk - profile_q[hi];
               hi--;
            end
            if (acc > TOTAL_CEIL) acc = TOTAL_CEIL;
         end
         res.water_total = TOTAL_W'(acc);
         res.overflowed = bars_dropped;
         expected_q.push_back(res);
         profile_q.delete();
         bars_dropped = 1'b0;
      endfunction

      function void check_total(logic [TOTAL_W-1:0] total, logic ovf, realtime stamp);
         water_result_t exp_r;
         if (expected_q.size() == 0) begin
            $display("%0.1f ns: unexpected result: expected none, actual water_total %0d overflowed %0d",
                     stamp, total, ovf);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (total !== exp_r.water_total) begin
            $display("%0.1f ns: water_total mismatch: expected %0d, actual %0d",
                     stamp, exp_r.water_total, total);
            errors++;
         end
         if (ovf !== exp_r.overflowed) begin
            $display("%0.1f ns: overflowed mismatch: expected %0d, actual %0d",
                     stamp, exp_r.overflowed, ovf);
            errors++;
         end
      endfunction
   endclass

endpackage

### dv/tb_top.sv
// Top of the trapped-water testbench: clock, reset, item drivers, monitor.
// Depends on twv_pkg, water_check_pkg and the trapped_water_volume RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import twv_pkg::*;
   import water_check_pkg::*;

   localparam int ITEM_TARGET    = 1450;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RX_HOLD_CYCLES = 1500;
   localparam int SETTLE_CYCLES  = 16;

   typedef logic [IN_H_W-1:0] bar_list_t[$];
   typedef enum int {SHAPE_WIDE, SHAPE_TIES, SHAPE_BASIN} profile_shape_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               pop = 1'b0;
   logic [IN_H_W-1:0]  req_bar_height = '0;
   logic               req_last_bar = 1'b0;
   logic               full;
   logic               empty;
   logic [TOTAL_W-1:0] rsp_water_total;
   logic               rsp_overflowed;

   bit                 tx_idle = 1'b1;
   bit                 rx_idle = 1'b1;
   int                 rx_hold_req = 0;
   int unsigned        items_sent = 0;
   int unsigned        idle_cycles = 0;
   water_scoreboard    sb = new();

   trapped_water_volume #(
      .MAX_BARS    (STORE_DEPTH),
      .HEIGHT_BITS (IN_H_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_bar_height  (req_bar_height),
      .req_last_bar    (req_last_bar),
      .empty           (empty),
      .pop             (pop),
      .rsp_water_total (rsp_water_total),
      .rsp_overflowed  (rsp_overflowed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Offer each bar in turn; leave push high when the next item follows at once.
   task automatic send_profile(input bar_list_t bars);
      int gap;
      foreach (bars[i]) begin
         gap = tx_idle ? $urandom_range(0, 11) : 0;
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         push <= 1'b1;
         req_bar_height <= bars[i];
         req_last_bar <= (i == bars.size() - 1);
         do @(posedge clock); while (full);
         @(negedge clock);
         items_sent++;
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic bar_list_t random_profile(int unsigned len);
      bar_list_t      bars;
      profile_shape_t shape;
      shape = profile_shape_t'($urandom_range(0, 2));
      for (int unsigned k = 0; k < len; k++) begin
         case (shape)
            SHAPE_TIES: begin
               bars.push_back(IN_H_W'($urandom_range(0, 7)));
            end
            SHAPE_BASIN: begin
               if (k == 0 || k == len - 1) bars.push_back(IN_H_W'($urandom_range(60000, 65535)));
               else bars.push_back(IN_H_W'($urandom_range(0, 300)));
            end
            default: begin
               bars.push_back(IN_H_W'($urandom_range(0, 65535)));
            end
         endcase
      end
      return bars;
   endfunction

   initial begin : result_sink
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rx_hold_req > 0) begin
            stall = rx_hold_req;
            rx_hold_req = 0;
         end else begin
            stall = rx_idle ? $urandom_range(0, 11) : 0;
         end
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (push && !full) sb.note_bar(req_bar_height, req_last_bar);
         if (pop && !empty) sb.check_total(rsp_water_total, rsp_overflowed, $realtime);
         if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      bar_list_t   bars;
      int unsigned n_profiles;
      int unsigned len;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single bars, two bars, equal ends, a deep basin and textbook profiles
      bars = '{16'd0};
      send_profile(bars);
      bars = '{16'd65535};
      send_profile(bars);
      bars = '{16'd0, 16'd65535};
      send_profile(bars);
      bars = '{16'd65535, 16'd0, 16'd65535};
      send_profile(bars);
      bars = '{16'd0, 16'd1, 16'd0, 16'd2, 16'd1, 16'd0, 16'd1, 16'd3, 16'd2, 16'd1,
               16'd2, 16'd1};
      send_profile(bars);
      bars = '{16'd4, 16'd2, 16'd0, 16'd3, 16'd2, 16'd5};
      send_profile(bars);

      n_profiles = 0;
      while (items_sent < ITEM_TARGET) begin
         if (n_profiles % 8 == 0) begin
            tx_idle = $urandom_range(0, 2) != 0;
            rx_idle = $urandom_range(0, 2) != 0;
         end
         if (n_profiles == 5) begin
            // overfill the store: the last three bars, the final one among them, are dropped
            bars.delete();
            bars.push_back(IN_H_W'(65535));
            for (int k = 1; k < STORE_DEPTH + 3; k++) begin
               if (k == STORE_DEPTH - 1) bars.push_back(IN_H_W'(65535));
               else bars.push_back(IN_H_W'($urandom_range(0, 4095)));
            end
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
            bars = random_profile(len);
         end
         if (n_profiles == 12) begin
            // hold the result side and keep offering until the block backs up
            tx_idle = 1'b0;
            rx_hold_req = RX_HOLD_CYCLES;
         end
         if (n_profiles == 20) wait_drained();
         send_profile(bars);
         n_profiles++;
      end

      wait_drained();
      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### trapped_water_volume.f
design/twv_pkg.sv
design/twv_front.sv
design/twv_jobq.sv
design/twv_back.sv
design/trapped_water_volume.sv
design/twv_checker.sv
dv/water_check_pkg.sv
dv/tb_top.sv
